// ===== design/rbcm_pkg.sv =====
// Package: shared constants and types for the rational Bezier curve mapper.
`default_nettype none
package rbcm_pkg;
    localparam int FRAC_BITS = 16;
    localparam int TW        = FRAC_BITS + 1;          // t, u width (holds one)
    localparam int BW        = FRAC_BITS + 3;          // Bernstein term width
    localparam int CW        = BW + 8;                 // weighted term width
    localparam int DW        = CW + 2;                 // denominator width
    localparam int NW        = DW + 16;                // numerator width
    localparam logic [4:0] ROUNDS_MIN = 5'd6;
    localparam logic [4:0] ROUNDS_MAX = 5'd30;

    typedef enum logic [2:0] {
        REG_P0 = 3'd0, REG_P1 = 3'd1, REG_P2 = 3'd2, REG_P3 = 3'd3,
        REG_W1 = 3'd4, REG_W2 = 3'd5, REG_ROUNDS = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [23:0] w1;
        logic [23:0] w2;
    } t_curve_cfg;

    function automatic logic [TW-1:0] q16_to_int(input logic [15:0] v);
        logic [TW+15:0] w;
        begin
            w = {{TW{1'b0}}, v};
            if (FRAC_BITS >= 16) q16_to_int = TW'(w << (FRAC_BITS - 16));
            else                 q16_to_int = TW'(w >> (16 - FRAC_BITS));
        end
    endfunction
endpackage
`default_nettype wire

// ===== design/rbcm_eval.sv =====
// Curve evaluator: one shared multiplier and one restoring divider, sequenced.
`default_nettype none
module rbcm_eval (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [rbcm_pkg::TW-1:0]       i_t,
    input  wire rbcm_pkg::t_curve_cfg    i_cfg,
    output logic                         o_done,
    output logic [15:0]                  o_x,
    output logic [15:0]                  o_y
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIVX, S_DIVY, S_DONE} t_state;

    localparam int MW = 32;   // multiplier operand width
    localparam int NSTEP = 18;

    t_state r_state;
    logic [4:0] r_step;
    logic [5:0] r_cnt;
    logic [rbcm_pkg::TW-1:0] r_t, r_u;
    logic [rbcm_pkg::BW-1:0] r_t2, r_u2, r_b0, r_b1, r_b2, r_b3;
    logic [rbcm_pkg::CW-1:0] r_c1, r_c2;
    logic [rbcm_pkg::NW-1:0] r_nx, r_ny;
    logic [rbcm_pkg::DW-1:0] r_den;
    logic [rbcm_pkg::NW-1:0] r_rem, r_quo;
    logic [15:0] r_x, r_y;

    logic [MW-1:0] ma, mb;
    logic [2*MW-1:0] prod;
    assign prod = ma * mb;

    always_comb begin
        ma = '0;
        mb = '0;
        case (r_step)
            5'd0: begin ma = MW'(r_t);  mb = MW'(r_t);  end
            5'd1: begin ma = MW'(r_u);  mb = MW'(r_u);  end
            5'd2: begin ma = MW'(r_u2); mb = MW'(r_u);  end
            5'd3: begin ma = MW'(r_u2); mb = MW'(r_t);  end
            5'd4: begin ma = MW'(r_t2); mb = MW'(r_u);  end
            5'd5: begin ma = MW'(r_t2); mb = MW'(r_t);  end
            5'd6: begin ma = MW'(r_b1); mb = MW'(i_cfg.w1); end
            5'd7: begin ma = MW'(r_b2); mb = MW'(i_cfg.w2); end
            5'd8: begin ma = MW'(r_b0); mb = MW'(i_cfg.p0[31:16]); end
            5'd9: begin ma = MW'(r_c1); mb = MW'(i_cfg.p1[31:16]); end
            5'd10: begin ma = MW'(r_c2); mb = MW'(i_cfg.p2[31:16]); end
            5'd11: begin ma = MW'(r_b3); mb = MW'(i_cfg.p3[31:16]); end
            5'd12: begin ma = MW'(r_b0); mb = MW'(i_cfg.p0[15:0]); end
            5'd13: begin ma = MW'(r_c1); mb = MW'(i_cfg.p1[15:0]); end
            5'd14: begin ma = MW'(r_c2); mb = MW'(i_cfg.p2[15:0]); end
            5'd15: begin ma = MW'(r_b3); mb = MW'(i_cfg.p3[15:0]); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    logic [rbcm_pkg::BW-1:0] sh;
    assign sh = rbcm_pkg::BW'(prod >> rbcm_pkg::FRAC_BITS);
    logic [rbcm_pkg::BW+1:0] sh3;
    assign sh3 = rbcm_pkg::BW'(3) * (rbcm_pkg::BW+2)'(sh);

    // restoring divide step: one quotient bit per cycle
    logic [rbcm_pkg::NW:0] trial;
    logic [rbcm_pkg::NW-1:0] rem_sh;
    logic [rbcm_pkg::DW-1:0] den_eff;
    assign den_eff = (r_den == '0) ? rbcm_pkg::DW'(1) : r_den;
    assign rem_sh = {r_rem[rbcm_pkg::NW-2:0], r_quo[rbcm_pkg::NW-1]};
    assign trial = {1'b0, rem_sh} - (rbcm_pkg::NW+1)'(den_eff);

    logic [15:0] qsat;
    assign qsat = (|r_quo[rbcm_pkg::NW-1:16]) ? 16'hFFFF : r_quo[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_t <= i_t;
                    r_u <= rbcm_pkg::TW'(1 << rbcm_pkg::FRAC_BITS) - i_t;
                    r_step <= '0;
                    r_nx <= '0;
                    r_ny <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 5'd1;
                    case (r_step)
                        5'd0: r_t2 <= sh;
                        5'd1: r_u2 <= sh;
                        5'd2: r_b0 <= sh;
                        5'd3: r_b1 <= rbcm_pkg::BW'(sh3);
                        5'd4: r_b2 <= rbcm_pkg::BW'(sh3);
                        5'd5: r_b3 <= sh;
                        5'd6: r_c1 <= rbcm_pkg::CW'(prod >> 16);
                        5'd7: begin
                            r_c2 <= rbcm_pkg::CW'(prod >> 16);
                            r_den <= rbcm_pkg::DW'(r_b0) + rbcm_pkg::DW'(r_c1)
                                   + rbcm_pkg::DW'(rbcm_pkg::CW'(prod >> 16))
                                   + rbcm_pkg::DW'(r_b3);
                        end
                        5'd8, 5'd9, 5'd10, 5'd11:
                            r_nx <= r_nx + rbcm_pkg::NW'(prod);
                        5'd12, 5'd13, 5'd14: r_ny <= r_ny + rbcm_pkg::NW'(prod);
                        default: begin
                            r_ny <= r_ny + rbcm_pkg::NW'(prod);
                            r_rem <= '0;
                            r_quo <= r_nx;
                            r_cnt <= '0;
                            r_state <= S_DIVX;
                        end
                    endcase
                end
                S_DIVX, S_DIVY: begin
                    if (!trial[rbcm_pkg::NW]) begin
                        r_rem <= trial[rbcm_pkg::NW-1:0];
                        r_quo <= {r_quo[rbcm_pkg::NW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[rbcm_pkg::NW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(rbcm_pkg::NW)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        if (r_state == S_DIVX) begin
                            r_x <= qsat;
                            r_quo <= r_ny;
                            r_state <= S_DIVY;
                        end else begin
                            r_y <= qsat;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule
`default_nettype wire

// ===== design/rational_bezier_curve_map_core.sv =====
// Top level: APB registers, bisection sequencer and result register.
// One curve evaluation is 16 multiply steps, two restoring divides
// (x, then y) and a done state. Mode 0 evaluates once at the given t;
// mode 1 bisects on x for the clamped rounds (6 to 30), then evaluates.
// One transfer at a time: o_stall is high until the result is taken.
// Synchronous active-low reset restores the register defaults and idles.
`default_nettype none
module rational_bezier_curve_map_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_func,
    input  wire  [15:0] i_operand_value,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [15:0] o_x_out,
    output logic [15:0] o_y_out
);
    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_WAIT, S_FINAL, S_FWAIT, S_OUT} t_state;

    rbcm_pkg::t_curve_cfg r_cfg;
    logic [4:0] r_rounds;
    logic [2:0] widx;
    assign widx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p0 <= 32'h0;
            r_cfg.p1 <= 32'h55555555;
            r_cfg.p2 <= 32'hAAAAAAAA;
            r_cfg.p3 <= 32'hFFFFFFFF;
            r_cfg.w1 <= 24'h010000;
            r_cfg.w2 <= 24'h010000;
            r_rounds <= 5'd20;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (widx)
                rbcm_pkg::REG_P0: r_cfg.p0 <= pwdata;
                rbcm_pkg::REG_P1: r_cfg.p1 <= pwdata;
                rbcm_pkg::REG_P2: r_cfg.p2 <= pwdata;
                rbcm_pkg::REG_P3: r_cfg.p3 <= pwdata;
                rbcm_pkg::REG_W1: r_cfg.w1 <= pwdata[23:0];
                rbcm_pkg::REG_W2: r_cfg.w2 <= pwdata[23:0];
                rbcm_pkg::REG_ROUNDS: r_rounds <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            rbcm_pkg::REG_P0: prdata = r_cfg.p0;
            rbcm_pkg::REG_P1: prdata = r_cfg.p1;
            rbcm_pkg::REG_P2: prdata = r_cfg.p2;
            rbcm_pkg::REG_P3: prdata = r_cfg.p3;
            rbcm_pkg::REG_W1: prdata = {8'h0, r_cfg.w1};
            rbcm_pkg::REG_W2: prdata = {8'h0, r_cfg.w2};
            rbcm_pkg::REG_ROUNDS: prdata = {27'h0, r_rounds};
            default: prdata = 32'h0;
        endcase
    end

    t_state r_state;
    logic r_func;
    logic [15:0] r_target;
    logic [rbcm_pkg::TW-1:0] r_lo, r_hi, r_tq;
    logic [4:0] r_left;
    logic r_start;
    logic ev_done;
    logic [15:0] ev_x, ev_y;
    logic [rbcm_pkg::TW-1:0] mid;
    logic [4:0] rounds_c;

    assign mid = rbcm_pkg::TW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign rounds_c = (r_rounds < rbcm_pkg::ROUNDS_MIN) ? rbcm_pkg::ROUNDS_MIN :
                      (r_rounds > rbcm_pkg::ROUNDS_MAX) ? rbcm_pkg::ROUNDS_MAX : r_rounds;

    rbcm_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_t     (r_tq),
        .i_cfg   (r_cfg),
        .o_done  (ev_done),
        .o_x     (ev_x),
        .o_y     (ev_y)
    );

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_func <= i_func;
                    r_target <= i_operand_value;
                    r_lo <= '0;
                    r_hi <= rbcm_pkg::TW'(1 << rbcm_pkg::FRAC_BITS);
                    r_left <= rounds_c;
                    if (i_func) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_tq <= rbcm_pkg::q16_to_int(i_operand_value);
                        r_start <= 1'b1;
                        r_state <= S_FWAIT;
                    end
                end
                S_EVAL: begin
                    r_tq <= mid;
                    r_start <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: if (ev_done) begin
                    if (ev_x < r_target) r_lo <= r_tq;
                    else                 r_hi <= r_tq;
                    r_left <= r_left - 5'd1;
                    r_state <= (r_left == 5'd1) ? S_FINAL : S_EVAL;
                end
                S_FINAL: begin
                    r_tq <= mid;
                    r_start <= 1'b1;
                    r_state <= S_FWAIT;
                end
                S_FWAIT: if (ev_done) begin
                    o_x_out <= r_func ? 16'h0 : ev_x;
                    o_y_out <= ev_y;
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (!i_stall) begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_mode1_x_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_func) |-> o_x_out == 16'h0) else $error("mode 1 x not zero");
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> r_lo <= r_hi) else $error("bisection bracket inverted");
endmodule
`default_nettype wire
